FILE: design/onewire_bus_master_top_assert.svh
// assertion macros for the one-wire bus master checker
`ifndef ONEWIRE_BUS_MASTER_TOP_ASSERT_SVH
`define ONEWIRE_BUS_MASTER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define OWB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OWB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/owb_pkg.sv
// shared types and constants of the one-wire bus master
`timescale 1ns / 1ps

package owb_pkg;

  localparam int REG_W = 10;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_RESET = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_WRITE_START   = 3'd3;
  localparam logic [2:0] REG_WRITE_DATA    = 3'd4;
  localparam logic [2:0] REG_READ_LOW      = 3'd5;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [2:0] REG_READ_TAIL     = 3'd7;

  localparam logic [9:0] RST_RESET_LOW     = 10'd480;
  localparam logic [7:0] RST_PRESENCE_WAIT = 8'd70;
  localparam logic [9:0] RST_RESET_TAIL    = 10'd480;
  localparam logic [7:0] RST_WRITE_START   = 8'd10;
  localparam logic [7:0] RST_WRITE_DATA    = 8'd50;
  localparam logic [7:0] RST_READ_LOW      = 8'd5;
  localparam logic [7:0] RST_READ_SAMPLE   = 8'd5;
  localparam logic [7:0] RST_READ_TAIL     = 8'd50;

  typedef struct packed {
    logic [9:0] reset_low;
    logic [7:0] presence_wait;
    logic [9:0] reset_tail;
    logic [7:0] write_start;
    logic [7:0] write_data;
    logic [7:0] read_low;
    logic [7:0] read_sample;
    logic [7:0] read_tail;
  } timing_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] tx_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       device_present;
  } result_t;

endpackage

FILE: design/owb_cfg.sv
// timing register file written through the configuration channel
`timescale 1ns / 1ps

module owb_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_addr,
  input  logic [9:0]         cfg_data,
  output owb_pkg::timing_t   timing
);

  owb_pkg::timing_t timing_r;
  owb_pkg::timing_t timing_nxt;

  always_comb begin
    timing_nxt = timing_r;
    if (cfg_valid) begin
      unique case (cfg_addr)
        owb_pkg::REG_RESET_LOW:     timing_nxt.reset_low     = cfg_data;
        owb_pkg::REG_PRESENCE_WAIT: timing_nxt.presence_wait = cfg_data[7:0];
        owb_pkg::REG_RESET_TAIL:    timing_nxt.reset_tail    = cfg_data;
        owb_pkg::REG_WRITE_START:   timing_nxt.write_start   = cfg_data[7:0];
        owb_pkg::REG_WRITE_DATA:    timing_nxt.write_data    = cfg_data[7:0];
        owb_pkg::REG_READ_LOW:      timing_nxt.read_low      = cfg_data[7:0];
        owb_pkg::REG_READ_SAMPLE:   timing_nxt.read_sample   = cfg_data[7:0];
        owb_pkg::REG_READ_TAIL:     timing_nxt.read_tail     = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.reset_low     <= owb_pkg::RST_RESET_LOW;
      timing_r.presence_wait <= owb_pkg::RST_PRESENCE_WAIT;
      timing_r.reset_tail    <= owb_pkg::RST_RESET_TAIL;
      timing_r.write_start   <= owb_pkg::RST_WRITE_START;
      timing_r.write_data    <= owb_pkg::RST_WRITE_DATA;
      timing_r.read_low      <= owb_pkg::RST_READ_LOW;
      timing_r.read_sample   <= owb_pkg::RST_READ_SAMPLE;
      timing_r.read_tail     <= owb_pkg::RST_READ_TAIL;
    end else begin
      timing_r <= timing_nxt;
    end
  end

  assign timing = timing_r;

endmodule

FILE: design/owb_core.sv
// bus sequencer: advances the slot timing by one tick per beat
`timescale 1ns / 1ps

module owb_core #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  owb_pkg::item_t     item,
  input  owb_pkg::timing_t   timing,
  output owb_pkg::result_t   result
);

  localparam int CMP_W = (COUNT_WIDTH > owb_pkg::REG_W) ? COUNT_WIDTH : owb_pkg::REG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_WR_START = 4'd4,
    PH_WR_DATA  = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_TAIL  = 4'd8,
    PH_GAP      = 4'd9
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  owb_pkg::func_t           kind_r, kind_nxt;
  logic [COUNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic [2:0]               bit_r, bit_nxt;
  logic [7:0]               shift_r, shift_nxt;
  logic                     pres_r, pres_nxt;
  logic                     drive_r, drive_nxt;

  logic [COUNT_WIDTH-1:0]   cnt_inc;
  logic [owb_pkg::REG_W-1:0] limit;
  logic                     over;
  logic                     done;
  logic [7:0]               rx;

  // count limit of the current phase
  always_comb begin
    unique case (phase_r)
      PH_RST_LOW:  limit = timing.reset_low;
      PH_RST_WAIT: limit = owb_pkg::REG_W'(timing.presence_wait);
      PH_RST_TAIL: limit = timing.reset_tail;
      PH_WR_START: limit = owb_pkg::REG_W'(timing.write_start);
      PH_WR_DATA:  limit = owb_pkg::REG_W'(timing.write_data);
      PH_RD_LOW:   limit = owb_pkg::REG_W'(timing.read_low);
      PH_RD_WAIT:  limit = owb_pkg::REG_W'(timing.read_sample);
      PH_RD_TAIL:  limit = owb_pkg::REG_W'(timing.read_tail);
      default:     limit = '0;
    endcase
  end

  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign over    = (CMP_W'(cnt_inc) >= CMP_W'(limit)) || (cnt_inc == CNT_MAX);

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    drive_nxt = drive_r;
    done      = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (item.func != owb_pkg::FUNC_TICK) begin
          kind_nxt  = item.func;
          bit_nxt   = '0;
          cnt_nxt   = '0;
          drive_nxt = 1'b1;
          unique case (item.func)
            owb_pkg::FUNC_RESET: phase_nxt = PH_RST_LOW;
            owb_pkg::FUNC_WRITE: begin
              shift_nxt = item.tx_byte;
              phase_nxt = PH_WR_START;
            end
            default: begin
              shift_nxt = '0;
              phase_nxt = PH_RD_LOW;
            end
          endcase
        end
      end
      PH_RST_LOW: begin
        cnt_nxt = cnt_inc;
        if (over) begin
          phase_nxt = PH_RST_WAIT;
          drive_nxt = 1'b0;
          cnt_nxt   = '0;
        end
      end
      PH_RST_WAIT: begin
        cnt_nxt = cnt_inc;
        if (over) begin
          pres_nxt  = ~item.line_level;
          phase_nxt = PH_RST_TAIL;
          drive_nxt = 1'b0;
          cnt_nxt   = '0;
        end
      end
      PH_RST_TAIL: begin
        cnt_nxt = cnt_inc;
        if (over) begin
          phase_nxt = PH_IDLE;
          drive_nxt = 1'b0;
          cnt_nxt   = '0;
          done      = 1'b1;
        end
      end
      PH_WR_START: begin
        cnt_nxt = cnt_inc;
        if (over) begin
          phase_nxt = PH_WR_DATA;
          drive_nxt = ~shift_r[bit_r];
          cnt_nxt   = '0;
        end
      end
      PH_WR_DATA: begin
        cnt_nxt = cnt_inc;
        if (over) begin
          drive_nxt = 1'b0;
          cnt_nxt   = '0;
          if (bit_r == 3'd7) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            phase_nxt = PH_GAP;
          end
        end
      end
      PH_RD_LOW: begin
        cnt_nxt = cnt_inc;
        if (over) begin
          phase_nxt = PH_RD_WAIT;
          drive_nxt = 1'b0;
          cnt_nxt   = '0;
        end
      end
      PH_RD_WAIT: begin
        cnt_nxt = cnt_inc;
        if (over) begin
          shift_nxt = shift_r | (8'(item.line_level) << bit_r);
          phase_nxt = PH_RD_TAIL;
          drive_nxt = 1'b0;
          cnt_nxt   = '0;
        end
      end
      PH_RD_TAIL: begin
        cnt_nxt = cnt_inc;
        if (over) begin
          drive_nxt = 1'b0;
          cnt_nxt   = '0;
          if (bit_r == 3'd7) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            phase_nxt = PH_GAP;
          end
        end
      end
      PH_GAP: begin
        // one released tick between slots
        phase_nxt = (kind_r == owb_pkg::FUNC_READ) ? PH_RD_LOW : PH_WR_START;
        drive_nxt = 1'b1;
        cnt_nxt   = '0;
      end
      default: begin
        phase_nxt = PH_IDLE;
        drive_nxt = 1'b0;
        cnt_nxt   = '0;
      end
    endcase
  end

  assign rx = (done && kind_r == owb_pkg::FUNC_READ) ? shift_nxt : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= owb_pkg::FUNC_TICK;
      cnt_r   <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
      drive_r <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
      drive_r <= drive_nxt;
    end
  end

  always_comb begin
    result.drive_low      = drive_nxt;
    result.busy_res       = (phase_nxt != PH_IDLE);
    result.done_res       = done;
    result.rx_byte        = rx;
    result.device_present = pres_nxt;
  end

endmodule

FILE: design/onewire_bus_master_top.sv
// top level of the one-wire bus master
`timescale 1ns / 1ps

// one-wire bus master, one tick per input beat
// in_*: tick beats; in_tuser carries the command (0 tick only, 1 reset with
//   presence detect, 2 write byte, 3 read byte), in_tdata the write byte and
//   the sampled line level; a command seen while busy is ignored
// out_*: one result beat per input beat with the line drive, busy, done, the
//   received byte (on done of a read) and the presence flag
// cfg_*: timing registers in ticks, always ready; write only while idle
// path: input register, sequencer step, result register, then out_*
// throughput: one beat per cycle while out_tready is high; the input register
//   and the result register run as a two-stage pipeline, and the tick counter
//   advances once per beat
// reset: sequencer idle with the line released, presence flag clear, timing
//   registers at their default counts, both stages empty
// stall: while out_tready is low the result holds, the input stage holds one
//   beat, and in_tready drops once both are full; no beat is lost

module onewire_bus_master_top #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // tx_byte[7:0], line_level[8], zero[15:9]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // drive_low[0], busy_res[1], done_res[2],
                                  // rx_byte[10:3], device_present[11], zero[15:12]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [9:0]  cfg_data
);

  owb_pkg::timing_t timing;
  owb_pkg::item_t   s1_item_r;
  logic             s1_valid_r;
  owb_pkg::result_t step_res;
  owb_pkg::result_t out_res_r;
  logic             out_valid_r;
  logic             adv;

  assign cfg_ready = 1'b1;

  owb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  owb_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (s1_item_r),
    .timing  (timing),
    .result  (step_res)
  );

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.func       <= owb_pkg::func_t'(in_tuser);
      s1_item_r.tx_byte    <= in_tdata[7:0];
      s1_item_r.line_level <= in_tdata[8];
    end
    if (adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.device_present, out_res_r.rx_byte,
                       out_res_r.done_res, out_res_r.busy_res, out_res_r.drive_low};

endmodule

FILE: design/owb_checker.sv
// port-level checks of the one-wire bus master and their bind
`timescale 1ns / 1ps
`include "onewire_bus_master_top_assert.svh"

module owb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  `OWB_ASSERT_NOW(a_done_not_busy, out_tvalid && out_tdata[2], !out_tdata[1], "done while busy")
  `OWB_ASSERT_NOW(a_rx_only_done, out_tvalid && !out_tdata[2], out_tdata[10:3] == 8'd0, "rx without done")
  `OWB_ASSERT_NOW(a_drive_busy, out_tvalid && out_tdata[0], out_tdata[1], "line pulled while idle")
  `OWB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat dropped")

endmodule

bind onewire_bus_master_top owb_checker u_owb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
